// ===== src/saturating_voice_mixer_unit_assert.svh =====
// ----------------------------------------------------------------------------
// saturating voice mixer assertion macros
// shared concurrent assertion forms used by the mixer controller and datapath
// ----------------------------------------------------------------------------
`ifndef SATURATING_VOICE_MIXER_UNIT_ASSERT_SVH
`define SATURATING_VOICE_MIXER_UNIT_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define SVM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mixer assertion failed (same cycle)");

// next-cycle implication, disabled while reset is asserted
`define SVM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mixer assertion failed (next cycle)");

`endif

// ===== src/svm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svm_pkg
// types and constants shared by the saturating voice mixer modules
// ----------------------------------------------------------------------------
package svm_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int ADDR_W      = 16;
    localparam int LEN_W       = 17;
    localparam int SLOT_OUT_W  = 5;
    // base + position always fits in 18 bits
    localparam int ADDR_SUM_W  = 18;
    // reciprocal scaling for the address reduction
    localparam int RECIP_SHIFT = 30;
    localparam int RECIP_W     = 23;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_QUEUE = 2'd1,
        OP_TICK  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRITE,
        ST_QUEUE,
        ST_TICK,
        ST_DRAIN,
        ST_DONE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic start_tick;
        logic issue_write;
        logic issue_slot;
        logic do_queue;
        logic load_out;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic pipe_busy;
        logic last_slot;
        logic out_free;
    } sts_t;

    // one voice slot record
    typedef struct packed {
        logic [ADDR_W-1:0] base;
        logic [LEN_W-1:0]  length;
        logic [LEN_W-1:0]  position;
    } slot_row_t;

    // side data that travels with an address through the reduction pipe
    typedef struct packed {
        logic                we;
        logic                hit;
        logic [SAMPLE_W-1:0] data;
    } mod_tag_t;

endpackage

// ===== src/svm_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svm_in_if
// input channel of the voice mixer: opcode and operands with valid/ready
// ----------------------------------------------------------------------------
interface svm_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         opcode;
    logic [15:0]        address;
    logic signed [15:0] sample_value;
    logic [16:0]        sound_length;

    modport source (
        output valid, opcode, address, sample_value, sound_length,
        input  ready
    );

    modport sink (
        input  valid, opcode, address, sample_value, sound_length,
        output ready
    );
endinterface

// ===== src/svm_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svm_out_if
// result channel of the voice mixer with valid/ready
// ----------------------------------------------------------------------------
interface svm_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] mixed_sample;
    logic [4:0]         queued_slot;
    logic               queue_full;

    modport source (
        output valid, mixed_sample, queued_slot, queue_full,
        input  ready
    );

    modport sink (
        input  valid, mixed_sample, queued_slot, queue_full,
        output ready
    );
endinterface

// ===== src/svm_addr_mod.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svm_addr_mod
// three-stage pipeline reducing an 18-bit address sum modulo the memory depth
// ----------------------------------------------------------------------------
module svm_addr_mod #(
    parameter int MEMORY_DEPTH = 65536
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    input  logic [svm_pkg::ADDR_SUM_W-1:0]        in_x,
    input  svm_pkg::mod_tag_t                     in_tag,
    output logic                                  out_valid,
    output logic [$clog2(MEMORY_DEPTH)-1:0]       out_addr,
    output svm_pkg::mod_tag_t                     out_tag,
    output logic                                  busy
);
    import svm_pkg::*;

    localparam int AW = $clog2(MEMORY_DEPTH);
    localparam longint unsigned RECIP_L = (64'd1 << RECIP_SHIFT) / MEMORY_DEPTH;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);
    localparam bit NO_REDUCE = (MEMORY_DEPTH >= (1 << ADDR_SUM_W));
    localparam logic [ADDR_SUM_W-1:0] DEPTH_LO = ADDR_SUM_W'(MEMORY_DEPTH);
    localparam int PW = ADDR_SUM_W + RECIP_W;
    localparam int QW = PW - RECIP_SHIFT;
    localparam int WIDE = (AW > ADDR_SUM_W) ? AW : ADDR_SUM_W;

    logic                  v1_reg, v2_reg, v3_reg;
    logic [PW-1:0]         prod_reg;
    logic [ADDR_SUM_W-1:0] x1_reg, x2_reg;
    logic [ADDR_SUM_W-1:0] qd_reg;
    mod_tag_t              tag1_reg, tag2_reg, tag3_reg;
    logic [AW-1:0]         addr_reg;

    logic [QW-1:0]         quot;
    logic [ADDR_SUM_W-1:0] rem;
    logic [ADDR_SUM_W-1:0] red;
    logic [WIDE-1:0]       red_wide;

    // remainder with one correction step
    always_comb
    begin
        quot = prod_reg[PW-1:RECIP_SHIFT];
        rem  = x2_reg - qd_reg;
        if (rem >= DEPTH_LO)
        begin
            rem = rem - DEPTH_LO;
        end
        red      = NO_REDUCE ? x2_reg : rem;
        red_wide = WIDE'(red);
    end

    // stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // reciprocal multiply, quotient times depth, then remainder
    always_ff @(posedge clk)
    begin
        prod_reg <= PW'(in_x) * PW'(RECIP);
        x1_reg   <= in_x;
        tag1_reg <= in_tag;
        qd_reg   <= ADDR_SUM_W'(quot * DEPTH_LO);
        x2_reg   <= x1_reg;
        tag2_reg <= tag1_reg;
        addr_reg <= red_wide[AW-1:0];
        tag3_reg <= tag2_reg;
    end

    assign out_valid = v3_reg;
    assign out_addr  = addr_reg;
    assign out_tag   = tag3_reg;
    assign busy      = v1_reg | v2_reg | v3_reg;

endmodule

// ===== src/svm_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svm_ctrl
// controller state machine sequencing writes, queue claims and mix ticks
// ----------------------------------------------------------------------------
module svm_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  svm_pkg::op_t  opcode,
    input  svm_pkg::sts_t sts,
    output svm_pkg::cmd_t cmd
);
    import svm_pkg::*;
    `include "saturating_voice_mixer_unit_assert.svh"

    state_t state_reg, state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    case (opcode)
                        OP_WRITE: state_next = ST_WRITE;
                        OP_QUEUE: state_next = ST_QUEUE;
                        OP_TICK:
                        begin
                            cmd.start_tick = 1'b1;
                            state_next     = ST_TICK;
                        end
                        default:  state_next = ST_DONE;
                    endcase
                end
            end
            ST_WRITE:
            begin
                cmd.issue_write = 1'b1;
                state_next      = ST_DRAIN;
            end
            ST_QUEUE:
            begin
                cmd.do_queue = 1'b1;
                state_next   = ST_DONE;
            end
            ST_TICK:
            begin
                cmd.issue_slot = 1'b1;
                if (sts.last_slot)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!sts.pipe_busy)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // checks
    `SVM_ASSERT_NEXT(a_accept_leaves_idle, clk, rst_n, (in_valid && in_ready), (state_reg != ST_IDLE))
    `SVM_ASSERT_NOW(a_load_when_free, clk, rst_n, cmd.load_out, sts.out_free)
    `SVM_ASSERT_NEXT(a_last_slot_drains, clk, rst_n, (cmd.issue_slot && sts.last_slot), (state_reg == ST_DRAIN))

endmodule

// ===== src/svm_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svm_dp
// mixer datapath: slot table, sound memory, address pipe, accumulator, output
// ----------------------------------------------------------------------------
module svm_dp #(
    parameter int VOICE_SLOTS  = 32,
    parameter int MEMORY_DEPTH = 65536
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  svm_pkg::cmd_t                         cmd,
    output svm_pkg::sts_t                         sts,
    input  svm_pkg::op_t                          opcode,
    input  logic [svm_pkg::ADDR_W-1:0]            address,
    input  logic signed [svm_pkg::SAMPLE_W-1:0]   sample_value,
    input  logic [svm_pkg::LEN_W-1:0]             sound_length,
    input  logic                                  out_ready,
    output logic                                  out_valid,
    output logic signed [svm_pkg::SAMPLE_W-1:0]   mixed_sample,
    output logic [svm_pkg::SLOT_OUT_W-1:0]        queued_slot,
    output logic                                  queue_full
);
    import svm_pkg::*;
    `include "saturating_voice_mixer_unit_assert.svh"

    localparam int SW = (VOICE_SLOTS > 1) ? $clog2(VOICE_SLOTS) : 1;
    localparam int QW = (SW > SLOT_OUT_W) ? SW : SLOT_OUT_W;
    localparam int AW = $clog2(MEMORY_DEPTH);
    localparam logic [SW-1:0] LAST_SLOT = SW'(VOICE_SLOTS - 1);

    // storage
    slot_row_t            slot_mem [VOICE_SLOTS];
    logic [SAMPLE_W-1:0]  sound_mem [MEMORY_DEPTH];
    logic [VOICE_SLOTS-1:0] active_reg;

    // captured transaction
    op_t                  op_reg;
    logic [ADDR_W-1:0]    addr_in_reg;
    logic [SAMPLE_W-1:0]  data_in_reg;
    logic [LEN_W-1:0]     len_in_reg;

    // slot walk and first stage
    logic [SW-1:0]        slot_cnt_reg;
    logic                 p1_valid_reg;
    logic                 p1_act_reg;
    logic [SW-1:0]        p1_idx_reg;
    slot_row_t            row_rd_reg;

    // sample read and accumulate
    logic                 v4_reg;
    logic [SAMPLE_W-1:0]  smp_reg;
    logic signed [SAMPLE_W-1:0] sum_reg;

    // queue results and output register
    logic [SLOT_OUT_W-1:0] res_slot_reg;
    logic                  res_full_reg;
    logic                  out_valid_reg;
    logic signed [SAMPLE_W-1:0] out_mix_reg;
    logic [SLOT_OUT_W-1:0] out_slot_reg;
    logic                  out_full_reg;

    logic                  found;
    logic [SW-1:0]         free_idx;
    logic [QW-1:0]         free_wide;
    logic                  hit;
    logic [LEN_W-1:0]      new_pos;
    logic                  retire;
    slot_row_t             row_wb;
    logic                  mod_in_valid;
    logic [ADDR_SUM_W-1:0] mod_in_x;
    mod_tag_t              mod_in_tag;
    logic                  mod_out_valid;
    logic [AW-1:0]         mod_out_addr;
    mod_tag_t              mod_out_tag;
    logic                  mod_busy;
    logic [SAMPLE_W:0]     sum_ext;
    logic signed [SAMPLE_W-1:0] sum_sat;
    logic                  pipe_busy;

    // lowest free slot
    always_comb
    begin
        found    = 1'b0;
        free_idx = '0;
        for (int i = VOICE_SLOTS - 1; i >= 0; i--)
        begin
            if (!active_reg[i])
            begin
                found    = 1'b1;
                free_idx = SW'(i);
            end
        end
        free_wide = QW'(free_idx);
    end

    // per-slot step: sample hit, advance, retire
    always_comb
    begin
        hit     = p1_act_reg && (row_rd_reg.position < row_rd_reg.length);
        new_pos = hit ? (row_rd_reg.position + 1'b1) : row_rd_reg.position;
        retire  = p1_act_reg && !(new_pos < row_rd_reg.length);
        row_wb          = row_rd_reg;
        row_wb.position = new_pos;
    end

    // address pipe feed: write address or slot sample address
    always_comb
    begin
        mod_in_tag = '0;
        if (cmd.issue_write)
        begin
            mod_in_valid    = 1'b1;
            mod_in_x        = ADDR_SUM_W'(addr_in_reg);
            mod_in_tag.we   = 1'b1;
            mod_in_tag.data = data_in_reg;
        end
        else
        begin
            mod_in_valid   = p1_valid_reg;
            mod_in_x       = ADDR_SUM_W'(row_rd_reg.base) + ADDR_SUM_W'(row_rd_reg.position);
            mod_in_tag.hit = hit;
        end
    end

    svm_addr_mod #(
        .MEMORY_DEPTH (MEMORY_DEPTH)
    ) u_addr_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mod_in_valid),
        .in_x      (mod_in_x),
        .in_tag    (mod_in_tag),
        .out_valid (mod_out_valid),
        .out_addr  (mod_out_addr),
        .out_tag   (mod_out_tag),
        .busy      (mod_busy)
    );

    // saturating add
    always_comb
    begin
        sum_ext = {sum_reg[SAMPLE_W-1], sum_reg} + {smp_reg[SAMPLE_W-1], smp_reg};
        if (sum_ext[SAMPLE_W] != sum_ext[SAMPLE_W-1])
        begin
            sum_sat = sum_ext[SAMPLE_W] ? {1'b1, {(SAMPLE_W-1){1'b0}}}
                                        : {1'b0, {(SAMPLE_W-1){1'b1}}};
        end
        else
        begin
            sum_sat = sum_ext[SAMPLE_W-1:0];
        end
    end

    // transaction capture
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg      <= opcode;
            addr_in_reg <= address;
            data_in_reg <= sample_value;
            len_in_reg  <= sound_length;
        end
    end

    // slot table
    always_ff @(posedge clk)
    begin
        if (cmd.do_queue && found)
        begin
            slot_mem[free_idx] <= '{base: addr_in_reg, length: len_in_reg, position: '0};
        end
        else if (p1_valid_reg && p1_act_reg)
        begin
            slot_mem[p1_idx_reg] <= row_wb;
        end
        if (cmd.issue_slot)
        begin
            row_rd_reg <= slot_mem[slot_cnt_reg];
        end
    end

    // slot walk control and active flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg   <= '0;
            slot_cnt_reg <= '0;
            p1_valid_reg <= 1'b0;
            p1_act_reg   <= 1'b0;
            p1_idx_reg   <= '0;
        end
        else
        begin
            p1_valid_reg <= cmd.issue_slot;
            if (cmd.start_tick)
            begin
                slot_cnt_reg <= '0;
            end
            else if (cmd.issue_slot)
            begin
                slot_cnt_reg <= slot_cnt_reg + 1'b1;
                p1_act_reg   <= active_reg[slot_cnt_reg];
                p1_idx_reg   <= slot_cnt_reg;
            end
            if (cmd.do_queue && found)
            begin
                active_reg[free_idx] <= 1'b1;
            end
            else if (p1_valid_reg && retire)
            begin
                active_reg[p1_idx_reg] <= 1'b0;
            end
        end
    end

    // sound memory
    always_ff @(posedge clk)
    begin
        if (mod_out_valid && mod_out_tag.we)
        begin
            sound_mem[mod_out_addr] <= mod_out_tag.data;
        end
        if (mod_out_valid && !mod_out_tag.we && mod_out_tag.hit)
        begin
            smp_reg <= sound_mem[mod_out_addr];
        end
    end

    // accumulator and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg        <= 1'b0;
            sum_reg       <= '0;
            res_slot_reg  <= '0;
            res_full_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            v4_reg <= mod_out_valid && !mod_out_tag.we && mod_out_tag.hit;
            if (cmd.start_tick)
            begin
                sum_reg <= '0;
            end
            else if (v4_reg)
            begin
                sum_reg <= sum_sat;
            end
            if (cmd.capture)
            begin
                res_slot_reg <= '0;
                res_full_reg <= 1'b0;
            end
            else if (cmd.do_queue)
            begin
                res_slot_reg <= found ? free_wide[SLOT_OUT_W-1:0] : '0;
                res_full_reg <= !found;
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_mix_reg  <= (op_reg == OP_TICK) ? sum_reg : '0;
            out_slot_reg <= res_slot_reg;
            out_full_reg <= res_full_reg;
        end
    end

    assign pipe_busy     = p1_valid_reg | mod_busy | v4_reg;
    assign sts.pipe_busy = pipe_busy;
    assign sts.last_slot = (slot_cnt_reg == LAST_SLOT);
    assign sts.out_free  = !out_valid_reg || out_ready;

    assign out_valid    = out_valid_reg;
    assign mixed_sample = out_mix_reg;
    assign queued_slot  = out_slot_reg;
    assign queue_full   = out_full_reg;

    // checks
    `SVM_ASSERT_NOW(a_no_claim_during_walk, clk, rst_n, p1_valid_reg, !cmd.do_queue)
    `SVM_ASSERT_NOW(a_load_after_drain, clk, rst_n, cmd.load_out, !pipe_busy)
    `SVM_ASSERT_NOW(a_accumulate_only_tick, clk, rst_n, v4_reg, (op_reg == OP_TICK))

endmodule

// ===== src/saturating_voice_mixer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// saturating_voice_mixer_unit
// multi-voice 16-bit pcm mixer with saturating accumulation
// ----------------------------------------------------------------------------
// One transaction is worked on at a time. During a tick the controller walks
// the slot table one slot per cycle through its single read port, and every
// sample address then passes a three-stage modulo pipeline and a registered
// sound memory read before it is added. The next transaction is taken while
// a finished result still waits on the output channel. No clearing pass is
// needed after reset.
module saturating_voice_mixer_unit #(
    parameter int VOICE_SLOTS  = 32,
    parameter int MEMORY_DEPTH = 65536
) (
    input  logic      clk,
    input  logic      rst_n,
    svm_in_if.sink    item,
    svm_out_if.source result
);
    import svm_pkg::*;

    cmd_t cmd;
    sts_t sts;

    svm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (item.valid),
        .in_ready (item.ready),
        .opcode   (op_t'(item.opcode)),
        .sts      (sts),
        .cmd      (cmd)
    );

    svm_dp #(
        .VOICE_SLOTS  (VOICE_SLOTS),
        .MEMORY_DEPTH (MEMORY_DEPTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .opcode       (op_t'(item.opcode)),
        .address      (item.address),
        .sample_value (item.sample_value),
        .sound_length (item.sound_length),
        .out_ready    (result.ready),
        .out_valid    (result.valid),
        .mixed_sample (result.mixed_sample),
        .queued_slot  (result.queued_slot),
        .queue_full   (result.queue_full)
    );

endmodule

// ===== verif/svm_mix_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svm_mix_checker
// watches the item and result channels of the voice mixer, keeps its own
// image of the sample memory and voice slots, and compares every result
// transaction field by field with the one the mixer owes at that point
// ----------------------------------------------------------------------------
module svm_mix_checker #(
    parameter int VOICES = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    svm_in_if           item_ch,
    svm_out_if          result_ch,
    output int unsigned miscompares,
    output int unsigned results_owed
);
    import svm_pkg::*;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] mixed_sample;
        logic [SLOT_OUT_W-1:0]      queued_slot;
        logic                       queue_full;
    } mix_out_t;

    // sample memory image and voice slot table
    logic [SAMPLE_W-1:0] sample_ram [0:65535];
    logic                voice_on   [VOICES];
    logic [ADDR_W-1:0]   voice_base [VOICES];
    logic [LEN_W-1:0]    voice_pos  [VOICES];
    logic [LEN_W-1:0]    voice_len  [VOICES];

    // results still owed by the mixer, oldest first
    mix_out_t owed_mix [$];

    // apply one transaction to the image and return the result it produces
    function automatic mix_out_t apply_item(op_t op, logic [ADDR_W-1:0] addr,
            logic [SAMPLE_W-1:0] smp, logic [LEN_W-1:0] len);
        mix_out_t          res;
        int                acc;
        logic [ADDR_W-1:0] rd_addr;
        bit                claimed;
        res     = '0;
        acc     = 0;
        claimed = 1'b0;
        case (op)
            OP_WRITE:
            begin
                sample_ram[addr] = smp;
            end
            OP_QUEUE:
            begin
                // lowest free slot wins
                for (int i = 0; i < VOICES; i++)
                begin
                    if (!claimed && !voice_on[i])
                    begin
                        voice_on[i]     = 1'b1;
                        voice_base[i]   = addr;
                        voice_pos[i]    = '0;
                        voice_len[i]    = len;
                        res.queued_slot = SLOT_OUT_W'(i);
                        claimed         = 1'b1;
                    end
                end
                res.queue_full = !claimed;
            end
            OP_TICK:
            begin
                // walk active slots in index order, clip after every add
                for (int i = 0; i < VOICES; i++)
                begin
                    if (voice_on[i])
                    begin
                        if (voice_pos[i] < voice_len[i])
                        begin
                            rd_addr = ADDR_W'(voice_base[i] + voice_pos[i]);
                            acc += int'($signed(sample_ram[rd_addr]));
                            if (acc > 32767)
                                acc = 32767;
                            if (acc < -32768)
                                acc = -32768;
                            voice_pos[i] = voice_pos[i] + 1'b1;
                        end
                        if (voice_pos[i] >= voice_len[i])
                            voice_on[i] = 1'b0;
                    end
                end
                res.mixed_sample = SAMPLE_W'(acc);
            end
            default:
            begin
            end
        endcase
        return res;
    endfunction

    // result side is checked before the item of the same edge is applied
    always @(posedge clk or negedge rst_n)
    begin
        mix_out_t want;
        mix_out_t got;
        if (!rst_n)
        begin
            for (int i = 0; i < VOICES; i++)
                voice_on[i] = 1'b0;
            owed_mix.delete();
            miscompares  <= 0;
            results_owed <= 0;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                got.mixed_sample = result_ch.mixed_sample;
                got.queued_slot  = result_ch.queued_slot;
                got.queue_full   = result_ch.queue_full;
                if (owed_mix.size() == 0)
                begin
                    if (miscompares < 10)
                        $display("%0t: result with nothing owed: sample %0d slot %0d full %0b",
                                 $realtime, got.mixed_sample, got.queued_slot, got.queue_full);
                    miscompares <= miscompares + 1;
                end
                else
                begin
                    want = owed_mix.pop_front();
                    if (got.mixed_sample !== want.mixed_sample
                            || got.queued_slot !== want.queued_slot
                            || got.queue_full !== want.queue_full)
                    begin
                        if (miscompares < 10)
                            $display({"%0t: mix mismatch: want sample %0d slot %0d full %0b,",
                                      " got sample %0d slot %0d full %0b"},
                                     $realtime, want.mixed_sample, want.queued_slot,
                                     want.queue_full, got.mixed_sample, got.queued_slot,
                                     got.queue_full);
                        miscompares <= miscompares + 1;
                    end
                end
            end
            if (item_ch.valid && item_ch.ready)
                owed_mix.push_back(apply_item(op_t'(item_ch.opcode), item_ch.address,
                                              item_ch.sample_value, item_ch.sound_length));
            results_owed <= owed_mix.size();
        end
    end

endmodule

// ===== verif/saturating_voice_mixer_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// saturating_voice_mixer_unit_tb
// drives sample writes, voice claims and mix ticks into the mixer with random
// pacing on both channels; a directed opening covers clipping, address wrap,
// the unused opcode and an idle tick, then random songs, crowded slot tables
// and noise follow while the checker compares every result
// ----------------------------------------------------------------------------
module saturating_voice_mixer_unit_tb;
    import svm_pkg::*;

    localparam int          SLOTS         = 32;
    localparam int          DEPTH         = 65536;
    localparam int          HALF_PERIOD   = 10;
    localparam int          RESET_CYCLES  = 12;
    localparam int          ITEM_TARGET   = 1850;
    localparam int          CHOKE_CYCLES  = 600;
    localparam int          SETTLE_CYCLES = 60;
    localparam int unsigned TIMEOUT_NS    = 250_000_000;

    // sample addresses a claimed voice still has to read, one per tick
    typedef struct packed {
        logic [ADDR_W-1:0] base;
        int unsigned       length;
        int unsigned       played;
    } voice_span_t;

    logic clk;
    logic rst_n;

    svm_in_if  item_ch ();
    svm_out_if result_ch ();

    int unsigned miscompares;
    int unsigned results_owed;

    bit          sample_written [0:DEPTH-1];
    voice_span_t live_spans [$];
    int unsigned items_sent;
    bit          gapless;
    bit          choke_now;
    bit          choke_done;

    saturating_voice_mixer_unit #(
        .VOICE_SLOTS  (SLOTS),
        .MEMORY_DEPTH (DEPTH)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch)
    );

    svm_mix_checker #(
        .VOICES (SLOTS)
    ) mix_chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_ch      (item_ch),
        .result_ch    (result_ch),
        .miscompares  (miscompares),
        .results_owed (results_owed)
    );

    // clock
    initial
    begin
        clk = 1'b0;
    end

    always #HALF_PERIOD clk = ~clk;

    // run limit
    initial
    begin
        #(TIMEOUT_NS);
        $display("saturating_voice_mixer_unit_tb: errors");
        $finish;
    end

    // sender idle length: mostly short, now and then long
    function automatic int unsigned idle_gap();
        int unsigned roll;
        if (gapless)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 88)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // samples lean toward the rails so that mixes clip often
    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0, 1, 2: return 16'h7FFF - 16'($urandom_range(0, 15));
            3, 4, 5: return 16'h8000 + 16'($urandom_range(0, 15));
            6:       return '0;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    function automatic logic [LEN_W-1:0] pick_length();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return LEN_W'($urandom_range(1, 12));
        if (roll < 97)
            return LEN_W'($urandom_range(13, 120));
        return LEN_W'($urandom_range(121, 600));
    endfunction

    // length field where the operation ignores it
    function automatic logic [LEN_W-1:0] any_length();
        return LEN_W'($urandom_range(1, 65536));
    endfunction

    // most voices sit in a small region across the address wrap
    function automatic logic [ADDR_W-1:0] pick_base();
        if ($urandom_range(0, 4) < 3)
            return ADDR_W'(16'hFFC0 + $urandom_range(0, 127));
        return ADDR_W'($urandom);
    endfunction

    // offer one transaction and hold it until accepted
    task automatic drive_item(op_t op, logic [ADDR_W-1:0] addr,
            logic [SAMPLE_W-1:0] smp, logic [LEN_W-1:0] len);
        int unsigned gap;
        voice_span_t span;
        gap = idle_gap();
        if (gap != 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid        <= 1'b1;
        item_ch.opcode       <= op;
        item_ch.address      <= addr;
        item_ch.sample_value <= smp;
        item_ch.sound_length <= len;
        do
            @(posedge clk);
        while (!item_ch.ready);
        items_sent++;
        if (op == OP_WRITE)
            sample_written[addr] = 1'b1;
        if (op == OP_QUEUE)
        begin
            span.base   = addr;
            span.length = int'(len);
            span.played = 0;
            live_spans.push_back(span);
        end
    endtask

    // fill every address a voice may read on this tick, then tick
    task automatic run_tick();
        logic [ADDR_W-1:0] rd;
        for (int i = 0; i < live_spans.size(); i++)
        begin
            rd = ADDR_W'(live_spans[i].base + live_spans[i].played);
            if (!sample_written[rd])
                drive_item(OP_WRITE, rd, pick_sample(), any_length());
        end
        drive_item(OP_TICK, ADDR_W'($urandom), SAMPLE_W'($urandom), any_length());
        for (int i = live_spans.size() - 1; i >= 0; i--)
        begin
            live_spans[i].played++;
            if (live_spans[i].played >= live_spans[i].length)
                live_spans.delete(i);
        end
    endtask

    task automatic queue_voice(logic [LEN_W-1:0] len);
        drive_item(OP_QUEUE, pick_base(), SAMPLE_W'($urandom), len);
    endtask

    // a few voices, then a run of ticks with the odd rewrite
    task automatic play_song(int unsigned voices, int unsigned ticks);
        repeat (voices) queue_voice(pick_length());
        repeat (ticks)
        begin
            if ($urandom_range(0, 7) == 0)
                drive_item(OP_WRITE, pick_base(), pick_sample(), any_length());
            run_tick();
        end
    endtask

    // stop offering until every owed result has come back
    task automatic pause_until_drained();
        item_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (results_owed != 0);
    endtask

    // result side pacing, including one long hold-off on request
    initial
    begin : result_pacing
        int unsigned span;
        int unsigned style;
        result_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (choke_now && !choke_done)
            begin
                result_ch.ready <= 1'b0;
                repeat (CHOKE_CYCLES) @(posedge clk);
                choke_done = 1'b1;
            end
            else if ($urandom_range(0, 299) == 0)
            begin
                result_ch.ready <= 1'b0;
                repeat ($urandom_range(100, 400)) @(posedge clk);
            end
            else
            begin
                style = $urandom_range(0, 3);
                span  = $urandom_range(1, 40);
                while (span != 0 && !(choke_now && !choke_done))
                begin
                    case (style)
                        0:       result_ch.ready <= 1'b1;
                        1:       result_ch.ready <= ($urandom_range(0, 3) != 0);
                        2:       result_ch.ready <= ($urandom_range(0, 1) != 0);
                        default: result_ch.ready <= ($urandom_range(0, 7) == 0);
                    endcase
                    @(posedge clk);
                    span--;
                end
            end
        end
    end

    // reset, stimulus and verdict
    initial
    begin
        int unsigned giants_sent;
        int unsigned crowd;
        rst_n                = 1'b0;
        item_ch.valid        = 1'b0;
        item_ch.opcode       = OP_WRITE;
        item_ch.address      = '0;
        item_ch.sample_value = '0;
        item_ch.sound_length = '0;
        items_sent           = 0;
        giants_sent          = 0;
        gapless              = 1'b0;
        choke_now            = 1'b0;
        choke_done           = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // directed: field extremes, unused opcode, idle tick
        drive_item(OP_WRITE, 16'hFFFF, 16'h7FFF, LEN_W'(1));
        drive_item(OP_WRITE, 16'h0000, 16'h8000, LEN_W'(65536));
        drive_item(OP_WRITE, 16'h0001, 16'h0001, LEN_W'(65535));
        drive_item(OP_NONE, 16'hFFFF, 16'hFFFF, LEN_W'(65536));
        run_tick();
        // positive clipping, then a read across the address wrap
        drive_item(OP_QUEUE, 16'hFFFF, 16'h0000, LEN_W'(2));
        drive_item(OP_QUEUE, 16'hFFFF, 16'h0000, LEN_W'(1));
        drive_item(OP_QUEUE, 16'hFFFF, 16'h0000, LEN_W'(1));
        run_tick();
        run_tick();
        // negative clipping
        repeat (3) drive_item(OP_QUEUE, 16'h0000, 16'h0000, LEN_W'(1));
        run_tick();
        // single small voice
        drive_item(OP_QUEUE, 16'h0001, 16'h0000, LEN_W'(1));
        run_tick();

        pause_until_drained();

        // back-pressure: result side holds off while items keep coming
        gapless   = 1'b1;
        choke_now = 1'b1;
        play_song(6, 20);

        // random phases
        while (items_sent < ITEM_TARGET)
        begin
            gapless = ($urandom_range(0, 3) == 0);
            // a few voices far longer than the run, bit 16 of the length among them
            if (giants_sent < 3 && items_sent > 500 + 450 * giants_sent)
            begin
                case (giants_sent)
                    0:       queue_voice(LEN_W'(65536));
                    1:       queue_voice(LEN_W'(65535));
                    default: queue_voice(LEN_W'($urandom_range(20000, 65536)));
                endcase
                giants_sent++;
            end
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6, 7:
                begin
                    play_song($urandom_range(1, 6), $urandom_range(1, 24));
                end
                8, 9, 10:
                begin
                    // crowd the slot table so that later claims are refused
                    crowd = $urandom_range(20, 40);
                    repeat (crowd) queue_voice(LEN_W'($urandom_range(1, 8)));
                    repeat ($urandom_range(1, 10)) run_tick();
                end
                11, 12, 13:
                begin
                    repeat ($urandom_range(5, 40)) run_tick();
                end
                14, 15, 16:
                begin
                    repeat ($urandom_range(1, 10))
                        drive_item(OP_WRITE, ADDR_W'($urandom), pick_sample(), any_length());
                end
                17:
                begin
                    repeat ($urandom_range(1, 3))
                        drive_item(OP_NONE, ADDR_W'($urandom), SAMPLE_W'($urandom),
                                   any_length());
                end
                default:
                begin
                    pause_until_drained();
                end
            endcase
        end

        pause_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (miscompares == 0 && results_owed == 0)
            $display("saturating_voice_mixer_unit_tb: clean");
        else
            $display("saturating_voice_mixer_unit_tb: errors");
        $finish;
    end

endmodule
